[rtl/pts_pkg.sv]
// Shared types, codes and constants of the process tick scheduler.
package pts_pkg;

	localparam int MAX_JOBS_DEF = 16;
	localparam logic [15:0] QUANTUM_RST = 16'd500;
	localparam logic [4:0] JOB_COUNT_RST = 5'd16;
	localparam int DATA_W = 20;
	localparam int TICK_W = 32;
	localparam int DONE_W = 5;
	localparam logic [DONE_W-1:0] DONE_MAX = 5'd31;

	typedef enum logic [1:0] {
		POL_FIFO = 2'd0,
		POL_RR   = 2'd1,
		POL_SJF  = 2'd2,
		POL_PSJF = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		CFG_POLICY  = 2'd0,
		CFG_QUANTUM = 2'd1,
		CFG_JOBS    = 2'd2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LOAD,
		ST_RET,
		ST_RET_RING,
		ST_RING_MOD,
		ST_RING_SCAN,
		ST_ARR_INIT,
		ST_ARR,
		ST_SEL,
		ST_SEL_KEY,
		ST_SEL_SCAN,
		ST_RR_DIV,
		ST_RR_CHK,
		ST_COMMIT,
		ST_RUN_RD,
		ST_RUN_WR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic load_wr;
		logic retire;
		logic ring_none;
		logic ring_init;
		logic ring_sub;
		logic ring_step;
		logic ring_hit;
		logic ring_miss;
		logic ring_rr;
		logic scan_clr;
		logic scan_run;
		logic scan_min;
		logic rd_cur;
		logic sel_init;
		logic sel_key;
		logic pick_ring;
		logic div_init;
		logic div_step;
		logic commit;
		logic run_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic ret_cond;
		logic done_ge_n;
		logic rk_ge_n;
		logic rk_elig;
		logic rcnt_last;
		logic scan_done;
		logic cur_valid;
		policy_t policy;
		logic div_last;
		logic div_zero;
		logic run_cond;
		logic out_free;
	} status_t;

endpackage

[rtl/pts_ctrl.sv]
// Sequencer of the tick scheduler: walks one request through its phases.
module pts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pts_pkg::status_t  st,
	output pts_pkg::cmd_t     cmd
);

	pts_pkg::state_t state_q, state_d;
	logic ring_rr_q, ring_rr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::ST_IDLE;
			ring_rr_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ring_rr_q <= ring_rr_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ring_rr_d = ring_rr_q;
		cmd = '0;
		cmd.ring_rr = ring_rr_q;
		in_ready = 1'b0;
		case (state_q)
			pts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = pts_pkg::ST_DISPATCH;
				end
			end
			pts_pkg::ST_DISPATCH: begin
				state_d = st.func ? pts_pkg::ST_RET : pts_pkg::ST_LOAD;
			end
			pts_pkg::ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d = pts_pkg::ST_IDLE;
			end
			pts_pkg::ST_RET: begin
				if (st.ret_cond) begin
					cmd.retire = 1'b1;
					state_d = pts_pkg::ST_RET_RING;
				end else begin
					state_d = pts_pkg::ST_ARR_INIT;
				end
			end
			pts_pkg::ST_RET_RING: begin
				if (st.done_ge_n) begin
					cmd.ring_none = 1'b1;
					state_d = pts_pkg::ST_ARR_INIT;
				end else begin
					cmd.ring_init = 1'b1;
					ring_rr_d = 1'b0;
					state_d = pts_pkg::ST_RING_MOD;
				end
			end
			pts_pkg::ST_RING_MOD: begin
				if (st.rk_ge_n) cmd.ring_sub = 1'b1;
				else state_d = pts_pkg::ST_RING_SCAN;
			end
			pts_pkg::ST_RING_SCAN: begin
				if (st.rk_elig || st.rcnt_last) begin
					cmd.ring_hit = st.rk_elig;
					cmd.ring_miss = !st.rk_elig;
					state_d = ring_rr_q ? pts_pkg::ST_COMMIT : pts_pkg::ST_ARR_INIT;
				end else begin
					cmd.ring_step = 1'b1;
				end
			end
			pts_pkg::ST_ARR_INIT: begin
				cmd.scan_clr = 1'b1;
				state_d = pts_pkg::ST_ARR;
			end
			pts_pkg::ST_ARR: begin
				cmd.scan_run = 1'b1;
				if (st.scan_done) state_d = pts_pkg::ST_SEL;
			end
			pts_pkg::ST_SEL: begin
				if (st.cur_valid && (st.policy == pts_pkg::POL_FIFO ||
						st.policy == pts_pkg::POL_SJF)) begin
					state_d = pts_pkg::ST_RUN_RD;
				end else if (st.policy != pts_pkg::POL_RR) begin
					cmd.sel_init = 1'b1;
					cmd.rd_cur = 1'b1;
					state_d = pts_pkg::ST_SEL_KEY;
				end else if (!st.cur_valid) begin
					cmd.pick_ring = 1'b1;
					state_d = pts_pkg::ST_COMMIT;
				end else begin
					cmd.div_init = 1'b1;
					state_d = pts_pkg::ST_RR_DIV;
				end
			end
			pts_pkg::ST_SEL_KEY: begin
				cmd.sel_key = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = pts_pkg::ST_SEL_SCAN;
			end
			pts_pkg::ST_SEL_SCAN: begin
				cmd.scan_run = 1'b1;
				cmd.scan_min = 1'b1;
				if (st.scan_done) state_d = pts_pkg::ST_COMMIT;
			end
			pts_pkg::ST_RR_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) state_d = pts_pkg::ST_RR_CHK;
			end
			pts_pkg::ST_RR_CHK: begin
				if (st.div_zero) begin
					cmd.ring_init = 1'b1;
					ring_rr_d = 1'b1;
					state_d = pts_pkg::ST_RING_MOD;
				end else begin
					state_d = pts_pkg::ST_COMMIT;
				end
			end
			pts_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = pts_pkg::ST_RUN_RD;
			end
			pts_pkg::ST_RUN_RD: begin
				cmd.rd_cur = 1'b1;
				state_d = st.run_cond ? pts_pkg::ST_RUN_WR : pts_pkg::ST_OUT;
			end
			pts_pkg::ST_RUN_WR: begin
				cmd.run_wr = 1'b1;
				state_d = pts_pkg::ST_OUT;
			end
			pts_pkg::ST_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d = pts_pkg::ST_IDLE;
				end
			end
			default: state_d = pts_pkg::ST_IDLE;
		endcase
	end

endmodule

[rtl/pts_datapath.sv]
// Job table, scheduler state, scan engine, ring search and remainder unit.
module pts_datapath #(
	parameter int MAX_JOBS = pts_pkg::MAX_JOBS_DEF,
	parameter int SW = $clog2(MAX_JOBS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pts_pkg::cmd_t                 cmd,
	output pts_pkg::status_t              st,
	input  logic                          func,
	input  logic [pts_pkg::DATA_W-1:0]    ready_time,
	input  logic [pts_pkg::DATA_W-1:0]    work_length,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pts_pkg::TICK_W-1:0]    tick_index,
	output logic [SW-1:0]                 running_job,
	output logic [pts_pkg::DONE_W-1:0]    jobs_finished,
	output logic                          all_done
);

	localparam int IW = $clog2(MAX_JOBS);
	localparam int CW = (SW > pts_pkg::DONE_W) ? SW : pts_pkg::DONE_W;
	localparam logic [SW-1:0] NONE = SW'(MAX_JOBS);
	localparam int DW = pts_pkg::DATA_W;
	localparam int TW = pts_pkg::TICK_W;

	// configuration
	pts_pkg::policy_t policy_q;
	logic [15:0] quantum_q;
	logic [4:0] jobs_q;

	// job table
	logic [DW-1:0] arr_mem [MAX_JOBS];
	logic [DW-1:0] rem_mem [MAX_JOBS];
	logic [DW-1:0] arr_rd_s1, rem_rd_s1;
	logic [MAX_JOBS-1:0] arrived_q, nz_q, elig;

	// scheduler state
	logic [SW-1:0] cur_q, ring_q, pick_q, org_q, lp_q;
	logic [TW-1:0] clock_q, slice_q;
	logic [pts_pkg::DONE_W-1:0] done_q;

	// latched request
	logic func_q;
	logic [DW-1:0] rt_q, wl_q;

	// scan engine
	logic [SW-1:0] sc_q;
	logic v_s1, stop_q;
	logic [IW-1:0] idx_s1;
	logic [DW-1:0] best_q;
	logic best_vld_q;

	// ring search
	logic [SW:0] rk_q;
	logic [SW-1:0] rcnt_q;

	// remainder unit
	logic [TW-1:0] dn_q;
	logic [15:0] dr_q;
	logic [4:0] dcnt_q;

	// result register
	logic [TW-1:0] tick_q;
	logic [SW-1:0] run_q;
	logic [pts_pkg::DONE_W-1:0] fin_q;
	logic all_q, ov_q;

	logic [SW-1:0] n;
	logic [IW-1:0] cur_idx, lp_idx, rd_addr, rk_idx;
	logic cur_valid, done_ge_n;
	logic [DW-1:0] key;
	logic [TW-1:0] arr_ext;
	logic [15:0] q_eff;
	logic [16:0] dtrial;
	logic [SW:0] rk_inc;

	always_comb begin
		if (jobs_q == 5'd0) n = SW'(1);
		else if (CW'(jobs_q) > CW'(MAX_JOBS)) n = NONE;
		else n = SW'(jobs_q);
	end

	assign cur_idx = cur_q[IW-1:0];
	assign lp_idx = lp_q[IW-1:0];
	assign rk_idx = rk_q[IW-1:0];
	assign rd_addr = cmd.rd_cur ? cur_idx : sc_q[IW-1:0];
	assign cur_valid = (cur_q != NONE);
	assign done_ge_n = (CW'(done_q) >= CW'(n));
	assign key = (policy_q == pts_pkg::POL_FIFO) ? arr_rd_s1 : rem_rd_s1;
	assign arr_ext = TW'(arr_rd_s1);
	assign q_eff = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
	assign dtrial = {dr_q, dn_q[TW-1]};
	assign rk_inc = rk_q + 1'b1;

	always_comb begin
		for (int i = 0; i < MAX_JOBS; i++) begin
			elig[i] = (SW'(i) < n) && arrived_q[i] && nz_q[i];
		end
	end

	always_comb begin
		st.func = func_q;
		st.ret_cond = cur_valid && !nz_q[cur_idx];
		st.done_ge_n = done_ge_n;
		st.rk_ge_n = (rk_q >= (SW+1)'(n));
		st.rk_elig = elig[rk_idx];
		st.rcnt_last = (rcnt_q == n - 1'b1);
		st.scan_done = stop_q || (sc_q >= n && !v_s1);
		st.cur_valid = cur_valid;
		st.policy = policy_q;
		st.div_last = (dcnt_q == 5'd31);
		st.div_zero = (dr_q == 16'd0);
		st.run_cond = cur_valid && nz_q[cur_idx];
		st.out_free = !ov_q || out_ready;
	end

	// configuration port, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pts_pkg::POL_FIFO;
			quantum_q <= pts_pkg::QUANTUM_RST;
			jobs_q <= pts_pkg::JOB_COUNT_RST;
		end else if (cfg_valid) begin
			case (pts_pkg::cfg_reg_t'(cfg_index))
				pts_pkg::CFG_POLICY:  policy_q <= pts_pkg::policy_t'(cfg_data[1:0]);
				pts_pkg::CFG_QUANTUM: quantum_q <= cfg_data;
				pts_pkg::CFG_JOBS:    jobs_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load_wr && lp_q < NONE) begin
			arr_mem[lp_idx] <= rt_q;
			rem_mem[lp_idx] <= wl_q;
		end else if (cmd.run_wr) begin
			rem_mem[cur_idx] <= rem_rd_s1 - 1'b1;
		end
		arr_rd_s1 <= arr_mem[rd_addr];
		rem_rd_s1 <= rem_mem[rd_addr];
	end

	// request latch, remainder unit, payload of the search
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q <= func;
			rt_q <= ready_time;
			wl_q <= work_length;
		end
		if (cmd.div_init) begin
			dn_q <= clock_q - slice_q;
			dr_q <= '0;
		end else if (cmd.div_step) begin
			dn_q <= {dn_q[TW-2:0], 1'b0};
			dr_q <= (dtrial >= {1'b0, q_eff}) ? 16'(dtrial - {1'b0, q_eff}) : dtrial[15:0];
		end
		if (cmd.sel_key) best_q <= key;
		else if (cmd.scan_min && v_s1 && elig[idx_s1] && (!best_vld_q || key < best_q))
			best_q <= key;
		if (cmd.scan_run && sc_q < n && !stop_q) idx_s1 <= sc_q[IW-1:0];
		if (cmd.ring_init) rk_q <= {1'b0, org_q} + 1'b1;
		else if (cmd.ring_sub) rk_q <= rk_q - (SW+1)'(n);
		else if (cmd.ring_step) rk_q <= (rk_inc == (SW+1)'(n)) ? '0 : rk_inc;
		if (cmd.out_load) begin
			tick_q <= clock_q;
			run_q <= cur_q;
			fin_q <= done_q;
			all_q <= done_ge_n;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrived_q <= '0;
			nz_q <= '0;
			cur_q <= NONE;
			ring_q <= NONE;
			pick_q <= NONE;
			org_q <= NONE;
			lp_q <= '0;
			clock_q <= '0;
			slice_q <= '0;
			done_q <= '0;
			sc_q <= '0;
			v_s1 <= 1'b0;
			stop_q <= 1'b0;
			best_vld_q <= 1'b0;
			rcnt_q <= '0;
			dcnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (cmd.load_wr && lp_q < NONE) begin
				nz_q[lp_idx] <= (wl_q != '0);
				lp_q <= lp_q + 1'b1;
			end
			if (cmd.retire) begin
				if (done_q < pts_pkg::DONE_MAX) done_q <= done_q + 1'b1;
				arrived_q[cur_idx] <= 1'b0;
				org_q <= cur_q;
				cur_q <= NONE;
			end
			if (cmd.ring_none) ring_q <= NONE;
			if (cmd.ring_init) rcnt_q <= '0;
			if (cmd.ring_step) rcnt_q <= rcnt_q + 1'b1;
			if (cmd.ring_hit) begin
				if (cmd.ring_rr) pick_q <= rk_q[SW-1:0];
				else ring_q <= rk_q[SW-1:0];
			end
			if (cmd.ring_miss && !cmd.ring_rr) ring_q <= NONE;
			// scan engine: issue one slot a cycle, evaluate it the cycle after
			if (cmd.scan_clr) begin
				sc_q <= '0;
				v_s1 <= 1'b0;
				stop_q <= 1'b0;
			end else if (cmd.scan_run) begin
				if (sc_q < n && !stop_q) begin
					v_s1 <= 1'b1;
					sc_q <= sc_q + 1'b1;
				end else begin
					v_s1 <= 1'b0;
				end
				if (v_s1 && !stop_q) begin
					if (cmd.scan_min) begin
						if (elig[idx_s1] && (!best_vld_q || key < best_q)) begin
							pick_q <= SW'(idx_s1);
							best_vld_q <= 1'b1;
						end
					end else begin
						if (arr_ext == clock_q) begin
							arrived_q[idx_s1] <= 1'b1;
							if (!cur_valid && ring_q == NONE) ring_q <= SW'(idx_s1);
						end
						// user must load sorted (not enforced), so later slots are not due
						if (arr_ext > clock_q) stop_q <= 1'b1;
					end
				end
			end
			if (cmd.sel_init) begin
				pick_q <= cur_q;
				best_vld_q <= 1'b0;
			end
			if (cmd.sel_key) best_vld_q <= cur_valid;
			if (cmd.pick_ring) pick_q <= ring_q;
			if (cmd.div_init) begin
				pick_q <= cur_q;
				org_q <= cur_q;
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.commit && pick_q != cur_q) begin
				cur_q <= pick_q;
				slice_q <= clock_q;
			end
			if (cmd.run_wr) nz_q[cur_idx] <= (rem_rd_s1 != DW'(1));
			if (cmd.out_load) begin
				ov_q <= 1'b1;
				clock_q <= clock_q + 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign tick_index = tick_q;
	assign running_job = run_q;
	assign jobs_finished = fin_q;
	assign all_done = all_q;

	a_done_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> done_q >= $past(done_q))
		else $error("finished count went down");
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_run && v_s1) |-> (SW'(idx_s1) < n))
		else $error("scan evaluated a slot beyond the job count");
	a_ring_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ring_hit |-> (rk_q < (SW+1)'(n)) && elig[rk_idx])
		else $error("ring search hit an ineligible slot");
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> cur_q <= NONE)
		else $error("running slot out of range");

endmodule

[rtl/process_tick_scheduler_unit.sv]
// Top level of the process tick scheduler: sequencer plus datapath.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------
//  in      | func, ready_time, work_length             | in_valid / in_ready
//  out     | tick_index, running_job, jobs_finished,   | out_valid / out_ready
//          | all_done                                  |
//  cfg     | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
// A tick request under SJF, PSJF and FIFO with no job running makes one arrival
// scan and one minimum scan over the single read port of the job table, one slot
// a cycle. FIFO and SJF with a running job skip the minimum scan. Under round
// robin with a running job, a 32-step remainder unit checks the quantum in place
// of the minimum scan, followed by a ring search when the slice expires. A
// finished job that retires adds a ring search of its own, with one more step per
// wrap when a lowered job count leaves the old slot past the ring. The arrival
// scan ends early at the first slot not yet due.
// Reset is asynchronous and active low; the job table itself is not cleared.
// The result register holds a tick result until out_ready; the next request is
// taken meanwhile, and a tick waits at its end only if that register is full.
// Configuration writes are always accepted.
module process_tick_scheduler_unit #(
	parameter int MAX_JOBS = pts_pkg::MAX_JOBS_DEF,
	parameter int SW = $clog2(MAX_JOBS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [pts_pkg::DATA_W-1:0]    ready_time,
	input  logic [pts_pkg::DATA_W-1:0]    work_length,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pts_pkg::TICK_W-1:0]    tick_index,
	output logic [SW-1:0]                 running_job,
	output logic [pts_pkg::DONE_W-1:0]    jobs_finished,
	output logic                          all_done
);

	pts_pkg::cmd_t cmd;
	pts_pkg::status_t st;

	// phase sequencer
	pts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// job table and scheduler state
	pts_datapath #(
		.MAX_JOBS (MAX_JOBS),
		.SW       (SW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.func          (func),
		.ready_time    (ready_time),
		.work_length   (work_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tick_index    (tick_index),
		.running_job   (running_job),
		.jobs_finished (jobs_finished),
		.all_done      (all_done)
	);

endmodule
